>>> rtl/cts_pkg.sv
`default_nettype none
package cts_pkg;

  localparam int unsigned NumSlotsDefault = 3;
  localparam logic [7:0] GlobalAddr = 8'hFF;

  typedef enum logic [2:0] {
    CmdRequest = 3'd0,
    CmdService = 3'd1,
    CmdCts     = 3'd2,
    CmdAbort   = 3'd3,
    CmdEack    = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    PhIdle     = 3'd0,
    PhAnnounce = 3'd1,
    PhWaitCts  = 3'd2,
    PhData     = 3'd3,
    PhWaitEack = 3'd4,
    PhEack     = 3'd5,
    PhExtAbort = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    MsgNone     = 3'd0,
    MsgRts      = 3'd1,
    MsgBam      = 3'd2,
    MsgData     = 3'd3,
    MsgAbortTo  = 3'd4,
    MsgAbortRes = 3'd5
  } msg_e;

  typedef enum logic [1:0] {
    TmrNone  = 2'd0,
    TmrBcast = 2'd1,
    TmrDirect = 2'd2,
    TmrResp  = 2'd3
  } timer_e;

  typedef enum logic [2:0] {
    NoteNone   = 3'd0,
    NoteSupply = 3'd1,
    NoteIntAbt = 3'd2,
    NoteExtAbt = 3'd3,
    NoteEack   = 3'd4
  } note_e;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StDiv,
    StExec,
    StDone
  } state_e;

endpackage
`default_nettype wire

>>> rtl/can_transport_segment_sender_top.sv
`default_nettype none
// Sender side of the CAN multi-packet transport protocol with a table of
// NUM_SLOTS connections.
// A request is taken at a rising edge where start_i is high and busy_o is
// low. Its fields pick one of five events: new transfer, service of one
// slot, received clear-to-send, received abort or received end ack.
// Every request yields exactly one result, shown for one cycle with
// done_o high; the receiver cannot stall it.
// A sequencer walks the slot table one entry per cycle with a shared
// address compare. For a new transfer a divide state then forms the
// packet count with a reciprocal multiply by one seventh. An execute
// state then updates the slot and registers the result.
// done_o is high in the done state, which follows the execute state.
// busy_o stays high up to and including that cycle, so no new request
// is taken before the last one is done; one request is in work at a time.
// Reset marks every slot inactive; the other slot fields are written
// before they are read.
module can_transport_segment_sender_top #(
  parameter int unsigned NUM_SLOTS = cts_pkg::NumSlotsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  output logic             done_o,
  input  wire logic [2:0]  cmd_i,
  input  wire logic [1:0]  slot_i,
  input  wire logic [7:0]  peer_addr_i,
  input  wire logic [17:0] group_number_i,
  input  wire logic [10:0] byte_count_i,
  input  wire logic [7:0]  grant_packets_i,
  input  wire logic [7:0]  grant_first_seq_i,
  input  wire logic        supplier_close_i,
  output logic             accepted_o,
  output logic [1:0]       slot_used_o,
  output logic [2:0]       msg_kind_o,
  output logic [7:0]       msg_dest_o,
  output logic [17:0]      msg_group_o,
  output logic [10:0]      msg_bytes_o,
  output logic [7:0]       msg_packets_o,
  output logic [7:0]       msg_seq_o,
  output logic [1:0]       timer_kind_o,
  output logic [2:0]       supplier_note_o
);

  localparam int unsigned IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(NUM_SLOTS + 1);

  cts_pkg::phase_e  phase_q [NUM_SLOTS];
  logic [7:0]       peer_q  [NUM_SLOTS];
  logic [17:0]      group_q [NUM_SLOTS];
  logic [10:0]      bytes_q [NUM_SLOTS];
  logic [7:0]       pkts_q  [NUM_SLOTS];
  logic [7:0]       seq_q   [NUM_SLOTS];
  logic [7:0]       grant_q [NUM_SLOTS];
  logic             sent_q  [NUM_SLOTS];

  cts_pkg::state_e state_q, state_d;

  // Latched request.
  logic [2:0]  cmd_q;
  logic [1:0]  slot_q;
  logic [7:0]  peer_r_q;
  logic [17:0] grp_r_q;
  logic [10:0] nbytes_q;
  logic [7:0]  gcnt_q;
  logic [7:0]  gfirst_q;
  logic        close_q;

  // Scan results.
  logic [CntW-1:0] scan_q;
  logic            match_hit_q, free_hit_q;
  logic [IdxW-1:0] match_idx_q, free_idx_q;
  // Packet count: (bytes + 6) * 9363 >> 16 equals the quotient by seven for
  // every 11-bit byte count.
  logic [11:0] rem_q;
  logic [8:0]  quot_q;
  logic [25:0] prod;
  assign prod = rem_q * 14'd9363;

  logic [IdxW-1:0] scan_idx;
  logic            scan_last;
  logic            scan_act, scan_match;
  assign scan_idx  = scan_q[IdxW-1:0];
  assign scan_last = (scan_q == CntW'(NUM_SLOTS - 1));
  assign scan_act  = (phase_q[scan_idx] != cts_pkg::PhIdle);
  assign scan_match = scan_act && (peer_q[scan_idx] == peer_r_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cts_pkg::StIdle: if (start_i) state_d = cts_pkg::StScan;
      cts_pkg::StScan: if (scan_last) begin
        state_d = (cmd_q == cts_pkg::CmdRequest) ? cts_pkg::StDiv : cts_pkg::StExec;
      end
      cts_pkg::StDiv:  state_d = cts_pkg::StExec;
      cts_pkg::StExec: state_d = cts_pkg::StDone;
      cts_pkg::StDone: state_d = cts_pkg::StIdle;
      default:         state_d = cts_pkg::StIdle;
    endcase
  end

  always_comb begin
    busy_o = (state_q != cts_pkg::StIdle);
    done_o = (state_q == cts_pkg::StDone);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cts_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == cts_pkg::StIdle && start_i) begin
      cmd_q       <= cmd_i;
      slot_q      <= slot_i;
      peer_r_q    <= peer_addr_i;
      grp_r_q     <= group_number_i;
      nbytes_q    <= byte_count_i;
      gcnt_q      <= grant_packets_i;
      gfirst_q    <= grant_first_seq_i;
      close_q     <= supplier_close_i;
      scan_q      <= '0;
      match_hit_q <= 1'b0;
      free_hit_q  <= 1'b0;
      match_idx_q <= '0;
      free_idx_q  <= '0;
      rem_q       <= {1'b0, byte_count_i} + 12'd6;
      quot_q      <= '0;
    end else if (state_q == cts_pkg::StScan) begin
      scan_q <= scan_q + CntW'(1);
      if (scan_match && !match_hit_q) begin
        match_hit_q <= 1'b1;
        match_idx_q <= scan_idx;
      end
      if (!scan_act && !free_hit_q) begin
        free_hit_q <= 1'b1;
        free_idx_q <= scan_idx;
      end
    end else if (state_q == cts_pkg::StDiv) begin
      quot_q <= prod[24:16];
    end
  end

  // Selected slot for service and received messages.
  logic            svc_ok;
  logic [IdxW-1:0] sel;
  assign svc_ok = ({3'b000, slot_q} < 5'(NUM_SLOTS));
  assign sel = (cmd_q == cts_pkg::CmdService) ? IdxW'(slot_q) : match_idx_q;

  cts_pkg::phase_e ph;
  logic        glob;
  logic [8:0]  nxt9, lim9, sum9;
  logic [7:0]  gl_dec;
  assign ph     = phase_q[sel];
  assign glob   = (peer_q[sel] == cts_pkg::GlobalAddr);
  assign lim9   = {1'b0, pkts_q[sel]} + 9'd1;
  assign nxt9   = {1'b0, seq_q[sel]} + 9'd1;
  assign sum9   = (cmd_q == cts_pkg::CmdCts) ? ({1'b0, gfirst_q} + {1'b0, gcnt_q})
                                             : ({1'b0, seq_q[sel]} + {1'b0, grant_q[sel]});
  assign gl_dec = grant_q[sel] - 8'd1;

  // Result and table update in one step.
  logic        r_acc;
  logic [2:0]  r_kind, r_note;
  logic [1:0]  r_tmr;
  logic        r_dest_en, r_grp_en, r_ann, r_seq_en;
  logic        wr_new, wr_ph, wr_seq, wr_gr, wr_sent;
  cts_pkg::phase_e new_ph;
  logic [7:0]  new_seq, new_gr;
  logic [IdxW-1:0] wr_idx;

  always_comb begin
    r_acc = 1'b0; r_kind = cts_pkg::MsgNone; r_note = cts_pkg::NoteNone;
    r_tmr = cts_pkg::TmrNone; r_dest_en = 1'b0; r_grp_en = 1'b0;
    r_ann = 1'b0; r_seq_en = 1'b0;
    wr_new = 1'b0; wr_ph = 1'b0; wr_seq = 1'b0; wr_gr = 1'b0; wr_sent = 1'b0;
    new_ph = cts_pkg::PhIdle; new_seq = '0; new_gr = '0;
    wr_idx = sel;
    case (cmd_q)
      cts_pkg::CmdRequest: begin
        wr_idx = free_idx_q;
        if (!match_hit_q && free_hit_q) begin
          r_acc = 1'b1; wr_new = 1'b1;
        end
      end
      cts_pkg::CmdService: begin
        if (svc_ok && ph != cts_pkg::PhIdle && ph <= cts_pkg::PhExtAbort) begin
          r_acc = 1'b1;
          unique case (ph)
            cts_pkg::PhAnnounce: begin
              r_kind = glob ? cts_pkg::MsgBam : cts_pkg::MsgRts;
              r_dest_en = 1'b1; r_grp_en = 1'b1; r_ann = 1'b1;
              wr_seq = 1'b1; new_seq = 8'd1; wr_gr = 1'b1; wr_ph = 1'b1;
              if (glob) begin
                new_gr = pkts_q[sel]; new_ph = cts_pkg::PhData; r_tmr = cts_pkg::TmrBcast;
              end else begin
                new_ph = cts_pkg::PhWaitCts; r_tmr = cts_pkg::TmrResp;
              end
            end
            cts_pkg::PhWaitCts, cts_pkg::PhWaitEack: begin
              wr_ph = 1'b1; r_kind = cts_pkg::MsgAbortTo;
              r_dest_en = 1'b1; r_grp_en = 1'b1; r_note = cts_pkg::NoteIntAbt;
            end
            cts_pkg::PhData: begin
              wr_ph = 1'b1;
              if (grant_q[sel] == 8'd0 || sum9 > lim9) begin
                new_ph = cts_pkg::PhWaitCts; r_tmr = cts_pkg::TmrResp;
              end else begin
                r_note = cts_pkg::NoteSupply; r_dest_en = 1'b1;
                if (close_q) begin
                  r_kind = cts_pkg::MsgAbortRes; r_grp_en = 1'b1;
                end else begin
                  r_kind = cts_pkg::MsgData; r_seq_en = 1'b1;
                  wr_seq = 1'b1; new_seq = nxt9[7:0];
                  wr_gr = 1'b1; new_gr = gl_dec;
                  wr_sent = (nxt9 > {1'b0, pkts_q[sel]});
                  if (gl_dec != 8'd0) begin
                    new_ph = cts_pkg::PhData;
                    r_tmr = glob ? cts_pkg::TmrBcast : cts_pkg::TmrDirect;
                  end else if (!(sent_q[sel] || wr_sent)) begin
                    new_ph = cts_pkg::PhWaitCts; r_tmr = cts_pkg::TmrResp;
                  end else if (!glob) begin
                    new_ph = cts_pkg::PhWaitEack; r_tmr = cts_pkg::TmrResp;
                  end
                end
              end
            end
            cts_pkg::PhEack: begin
              wr_ph = 1'b1; r_note = cts_pkg::NoteEack;
            end
            default: begin
              wr_ph = 1'b1; r_note = cts_pkg::NoteExtAbt;
            end
          endcase
        end
      end
      cts_pkg::CmdCts, cts_pkg::CmdAbort, cts_pkg::CmdEack: begin
        if (match_hit_q && group_q[sel] == grp_r_q) begin
          if (cmd_q == cts_pkg::CmdCts) begin
            if ((ph == cts_pkg::PhWaitCts || ph == cts_pkg::PhWaitEack) &&
                gfirst_q != 8'd0 && sum9 <= lim9) begin
              r_acc = 1'b1; wr_ph = 1'b1; new_ph = cts_pkg::PhData;
              wr_gr = 1'b1; new_gr = gcnt_q; wr_seq = 1'b1; new_seq = gfirst_q;
            end
          end else if (cmd_q == cts_pkg::CmdAbort) begin
            r_acc = 1'b1; wr_ph = 1'b1; new_ph = cts_pkg::PhExtAbort;
          end else if (ph == cts_pkg::PhWaitEack) begin
            r_acc = 1'b1; wr_ph = 1'b1; new_ph = cts_pkg::PhEack;
          end
        end
      end
      default: ;
    endcase
  end

  logic exec;
  assign exec = (state_q == cts_pkg::StExec);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) phase_q[i] <= cts_pkg::PhIdle;
    end else if (exec && wr_new) begin
      phase_q[wr_idx] <= cts_pkg::PhAnnounce;
    end else if (exec && wr_ph) begin
      phase_q[wr_idx] <= new_ph;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec && wr_new) begin
      peer_q[wr_idx]  <= peer_r_q;
      group_q[wr_idx] <= grp_r_q;
      bytes_q[wr_idx] <= nbytes_q;
      pkts_q[wr_idx]  <= quot_q[8] ? 8'hFF : quot_q[7:0];
      seq_q[wr_idx]   <= 8'd1;
      sent_q[wr_idx]  <= 1'b0;
    end else if (exec) begin
      if (wr_seq)  seq_q[wr_idx]   <= new_seq;
      if (wr_gr)   grant_q[wr_idx] <= new_gr;
      if (wr_sent) sent_q[wr_idx]  <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      accepted_o      <= r_acc;
      slot_used_o     <= r_acc ? 2'(wr_idx) : 2'd0;
      msg_kind_o      <= r_kind;
      msg_dest_o      <= r_dest_en ? peer_q[sel] : 8'd0;
      msg_group_o     <= r_grp_en ? group_q[sel] : 18'd0;
      msg_bytes_o     <= r_ann ? bytes_q[sel] : 11'd0;
      msg_packets_o   <= r_ann ? pkts_q[sel] : 8'd0;
      msg_seq_o       <= r_seq_en ? seq_q[sel] : 8'd0;
      timer_kind_o    <= r_tmr;
      supplier_note_o <= r_note;
    end
  end

`ifndef SYNTHESIS
  a_done_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q) == cts_pkg::StExec) else $error("done without exec");
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("start not taken");
  a_done_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");
  a_no_accept_no_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !accepted_o) |-> slot_used_o == 2'd0) else $error("slot without accept");
`endif

endmodule
`default_nettype wire
